@@ hw/rtl/mpsm_pkg.sv @@
// ----------------------------------------------------------------------------
// mpsm_pkg
// Shared types and constants of the multi-pattern string matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package mpsm_pkg;

  localparam int NODES_DEF        = 256;
  localparam int ALPHABET_DEF     = 26;
  localparam int MAX_PATTERNS_DEF = 16;
  localparam int MAX_RESULTS      = 16;
  localparam int ID_W             = 4;
  localparam int SYM_W            = 5;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_BUILD   = 2'd1,
    OP_MATCH   = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK              = 3'd0,
    ST_TRIE_FULL       = 3'd1,
    ST_PAT_FULL        = 3'd2,
    ST_INS_AFTER_BUILD = 3'd3,
    ST_NOT_BUILT       = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RESP,
    S_INS_RD,
    S_INS_PAT,
    S_M_RD,
    S_M_LOAD,
    S_M_EMIT,
    S_B_POP,
    S_B_U,
    S_B_F,
    S_B_C1,
    S_B_C2,
    S_B_C3,
    S_B_C4
  } state_t;

  typedef struct packed {
    status_t         status;
    logic [ID_W-1:0] pattern_id;
    logic            match_valid;
    logic            last;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/mpsm_ram.sv @@
// ----------------------------------------------------------------------------
// mpsm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mpsm_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/mpsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// mpsm_ctrl
// Sequencer: trie insert, breadth-first build, text walk and result output.
// ----------------------------------------------------------------------------
`default_nettype none

module mpsm_ctrl import mpsm_pkg::*; #(
  parameter int NODES        = NODES_DEF,
  parameter int ALPHABET     = ALPHABET_DEF,
  parameter int MAX_PATTERNS = MAX_PATTERNS_DEF,
  localparam int NW     = $clog2(NODES),
  localparam int NCW    = $clog2(NODES + 1),
  localparam int GDEPTH = NODES * ALPHABET,
  localparam int GAW    = $clog2(GDEPTH),
  localparam int CW     = $clog2(ALPHABET)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [7:0]              in_tdata,
  input  wire logic                    in_tlast,
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic [7:0]                   out_tdata,
  output logic                         out_tlast,
  output logic                         g_we,
  output logic [GAW-1:0]               g_waddr,
  output logic [NW-1:0]                g_wdata,
  output logic [GAW-1:0]               g_raddr,
  input  wire logic [NW-1:0]           g_rdata,
  output logic                         l_we,
  output logic [NW-1:0]                l_waddr,
  output logic [2*NW-1:0]              l_wdata,
  output logic [NW-1:0]                n_raddr,
  input  wire logic [2*NW-1:0]         l_rdata,
  output logic                         p_we,
  output logic [NW-1:0]                p_waddr,
  output logic [MAX_PATTERNS-1:0]      p_wdata,
  input  wire logic [MAX_PATTERNS-1:0] p_rdata,
  output logic                         q_we,
  output logic [NW-1:0]                q_waddr,
  output logic [NW-1:0]                q_wdata,
  output logic [NW-1:0]                q_raddr,
  input  wire logic [NW-1:0]           q_rdata
);

  localparam int PIW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int PCW = $clog2(MAX_PATTERNS + 1);
  localparam int RW  = $clog2(MAX_RESULTS + 1);

  state_t                  state_r, state_nxt;
  logic [GAW-1:0]          clr_r, clr_nxt;
  logic [NCW-1:0]          node_cnt_r, node_cnt_nxt;
  logic [PCW-1:0]          pat_cnt_r, pat_cnt_nxt;
  logic [NW-1:0]           ins_r, ins_nxt;
  logic [NW-1:0]           text_r, text_nxt;
  logic                    built_r, built_nxt;
  logic [CW-1:0]           sym_r, sym_nxt;
  logic                    end_r, end_nxt;
  logic [NW-1:0]           nxt_node_r, nxt_node_nxt;
  logic [NCW-1:0]          head_r, head_nxt;
  logic [NCW-1:0]          tail_r, tail_nxt;
  logic [NW-1:0]           u_r, u_nxt;
  logic [NW-1:0]           fu_r, fu_nxt;
  logic [NW-1:0]           v_r, v_nxt;
  logic [NW-1:0]           f_r, f_nxt;
  logic [CW-1:0]           c_r, c_nxt;
  logic [MAX_PATTERNS-1:0] mask_r, mask_nxt;
  logic [NW-1:0]           olink_r, olink_nxt;
  logic [RW-1:0]           nres_r, nres_nxt;
  result_t                 resp_r, resp_nxt;
  logic                    out_valid_r;
  result_t                 out_res_r, out_res_nxt;
  logic                    out_load;
  logic                    slot_free;
  logic [CW-1:0]           sym_c;
  op_t                     in_op;
  logic [NW-1:0]           new_node;
  logic [NW-1:0]           ins_target;
  logic [NW-1:0]           f_c;
  logic [PIW-1:0]          p_sel;
  logic [MAX_PATTERNS-1:0] mask_rest;
  logic                    fin;

  function automatic logic [GAW-1:0] gaddr(input logic [NW-1:0] n, input logic [CW-1:0] c);
    return GAW'(GAW'(n) * GAW'(ALPHABET)) + GAW'(c);
  endfunction

  assign in_op     = op_t'(in_tdata[1:0]);
  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    if (32'(in_tdata[6:2]) >= ALPHABET) begin
      sym_c = CW'(ALPHABET - 1);
    end else begin
      sym_c = CW'(in_tdata[6:2]);
    end
  end

  always_comb begin
    p_sel = '0;
    for (int i = MAX_PATTERNS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        p_sel = PIW'(i);
      end
    end
  end

  assign mask_rest = mask_r & ~(MAX_PATTERNS'(1) << p_sel);
  assign fin       = ((mask_rest == '0) && (olink_r == '0))
                     || (32'(nres_r) + 1 >= MAX_RESULTS);
  assign new_node  = node_cnt_r[NW-1:0];

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    node_cnt_nxt = node_cnt_r;
    pat_cnt_nxt  = pat_cnt_r;
    ins_nxt      = ins_r;
    text_nxt     = text_r;
    built_nxt    = built_r;
    sym_nxt      = sym_r;
    end_nxt      = end_r;
    nxt_node_nxt = nxt_node_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    u_nxt        = u_r;
    fu_nxt       = fu_r;
    v_nxt        = v_r;
    f_nxt        = f_r;
    c_nxt        = c_r;
    mask_nxt     = mask_r;
    olink_nxt    = olink_r;
    nres_nxt     = nres_r;
    resp_nxt     = resp_r;
    out_load     = 1'b0;
    out_res_nxt  = resp_r;
    g_we         = 1'b0;
    g_waddr      = gaddr(u_r, c_r);
    g_wdata      = '0;
    g_raddr      = gaddr(ins_r, sym_r);
    l_we         = 1'b0;
    l_waddr      = v_r;
    l_wdata      = '0;
    n_raddr      = olink_r;
    p_we         = 1'b0;
    p_waddr      = nxt_node_r;
    p_wdata      = p_rdata | (MAX_PATTERNS'(1) << pat_cnt_r);
    q_we         = 1'b0;
    q_waddr      = tail_r[NW-1:0];
    q_wdata      = v_r;
    q_raddr      = head_r[NW-1:0];
    ins_target   = g_rdata;
    f_c          = '0;

    case (state_r)
      S_CLEAR: begin
        g_we    = 1'b1;
        g_waddr = clr_r;
        if (32'(clr_r) < NODES) begin
          l_we    = 1'b1;
          l_waddr = clr_r[NW-1:0];
          p_we    = 1'b1;
          p_waddr = clr_r[NW-1:0];
          p_wdata = '0;
        end
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == GDEPTH - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        g_raddr = gaddr((in_op == OP_MATCH) ? text_r : ins_r, sym_c);
        if (in_tvalid) begin
          sym_nxt  = sym_c;
          end_nxt  = in_tlast;
          resp_nxt = '{status: ST_OK, pattern_id: '0, match_valid: 1'b0, last: 1'b1};
          case (in_op)
            OP_INSERT: begin
              if (built_r) begin
                resp_nxt.status = ST_INS_AFTER_BUILD;
                state_nxt       = S_RESP;
              end else begin
                state_nxt = S_INS_RD;
              end
            end
            OP_BUILD: begin
              if (built_r) begin
                state_nxt = S_RESP;
              end else begin
                q_we      = 1'b1;
                q_waddr   = '0;
                q_wdata   = '0;
                head_nxt  = '0;
                tail_nxt  = NCW'(1);
                state_nxt = S_B_POP;
              end
            end
            OP_MATCH: begin
              if (!built_r) begin
                resp_nxt.status = ST_NOT_BUILT;
                state_nxt       = S_RESP;
              end else begin
                state_nxt = S_M_RD;
              end
            end
            OP_RESTART: begin
              text_nxt  = '0;
              state_nxt = S_RESP;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_RESP: begin
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_INS_RD: begin
        g_waddr   = gaddr(ins_r, sym_r);
        g_wdata   = new_node;
        state_nxt = S_RESP;
        if (g_rdata == '0 && 32'(node_cnt_r) >= NODES) begin
          ins_nxt         = '0;
          resp_nxt.status = ST_TRIE_FULL;
        end else begin
          if (g_rdata == '0) begin
            g_we         = 1'b1;
            node_cnt_nxt = node_cnt_r + 1'b1;
            ins_target   = new_node;
          end
          ins_nxt = ins_target;
          n_raddr = ins_target;
          if (end_r) begin
            ins_nxt = '0;
            if (32'(pat_cnt_r) >= MAX_PATTERNS) begin
              resp_nxt.status = ST_PAT_FULL;
            end else begin
              nxt_node_nxt = ins_target;
              state_nxt    = S_INS_PAT;
            end
          end
        end
      end
      S_INS_PAT: begin
        p_we                = 1'b1;
        resp_nxt.pattern_id = ID_W'(pat_cnt_r);
        pat_cnt_nxt         = pat_cnt_r + 1'b1;
        state_nxt           = S_RESP;
      end
      S_M_RD: begin
        text_nxt = g_rdata;
        n_raddr  = g_rdata;
        nres_nxt = '0;
        if (g_rdata == '0) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_M_LOAD;
        end
      end
      S_M_LOAD: begin
        mask_nxt  = p_rdata;
        olink_nxt = l_rdata[2*NW-1:NW];
        n_raddr   = l_rdata[2*NW-1:NW];
        if (p_rdata != '0) begin
          state_nxt = S_M_EMIT;
        end else if (l_rdata[2*NW-1:NW] == '0) begin
          state_nxt = S_RESP;
        end
      end
      S_M_EMIT: begin
        if (slot_free) begin
          out_load    = 1'b1;
          out_res_nxt = '{status: ST_OK, pattern_id: ID_W'(p_sel),
                          match_valid: 1'b1, last: fin};
          nres_nxt    = nres_r + 1'b1;
          mask_nxt    = mask_rest;
          if (fin) begin
            state_nxt = S_IDLE;
          end else if (mask_rest == '0) begin
            state_nxt = S_M_LOAD;
          end
        end
      end
      S_B_POP: begin
        if (head_r == tail_r) begin
          built_nxt = 1'b1;
          ins_nxt   = '0;
          state_nxt = S_RESP;
        end else begin
          head_nxt  = head_r + 1'b1;
          state_nxt = S_B_U;
        end
      end
      S_B_U: begin
        u_nxt     = q_rdata;
        n_raddr   = q_rdata;
        state_nxt = S_B_F;
      end
      S_B_F: begin
        fu_nxt    = l_rdata[NW-1:0];
        c_nxt     = '0;
        state_nxt = S_B_C1;
      end
      S_B_C1: begin
        g_raddr   = gaddr(u_r, c_r);
        state_nxt = S_B_C2;
      end
      S_B_C2: begin
        v_nxt     = g_rdata;
        g_raddr   = gaddr(fu_r, c_r);
        state_nxt = S_B_C3;
      end
      S_B_C3: begin
        f_c     = (u_r != '0) ? g_rdata : '0;
        f_nxt   = f_c;
        n_raddr = f_c;
        if (v_r == '0) begin
          g_we    = 1'b1;
          g_wdata = g_rdata;
          c_nxt   = c_r + 1'b1;
          if (32'(c_r) == ALPHABET - 1) begin
            state_nxt = S_B_POP;
          end else begin
            state_nxt = S_B_C1;
          end
        end else begin
          state_nxt = S_B_C4;
        end
      end
      S_B_C4: begin
        l_we    = 1'b1;
        l_wdata = {((p_rdata != '0) ? f_r : l_rdata[2*NW-1:NW]), f_r};
        if (32'(tail_r) < NODES) begin
          q_we     = 1'b1;
          tail_nxt = tail_r + 1'b1;
        end
        c_nxt = c_r + 1'b1;
        if (32'(c_r) == ALPHABET - 1) begin
          state_nxt = S_B_POP;
        end else begin
          state_nxt = S_B_C1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      node_cnt_r  <= NCW'(1);
      pat_cnt_r   <= '0;
      ins_r       <= '0;
      text_r      <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      node_cnt_r <= node_cnt_nxt;
      pat_cnt_r  <= pat_cnt_nxt;
      ins_r      <= ins_nxt;
      text_r     <= text_nxt;
      built_r    <= built_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sym_r      <= sym_nxt;
    end_r      <= end_nxt;
    nxt_node_r <= nxt_node_nxt;
    head_r     <= head_nxt;
    tail_r     <= tail_nxt;
    u_r        <= u_nxt;
    fu_r       <= fu_nxt;
    v_r        <= v_nxt;
    f_r        <= f_nxt;
    c_r        <= c_nxt;
    mask_r     <= mask_nxt;
    olink_r    <= olink_nxt;
    nres_r     <= nres_nxt;
    resp_r     <= resp_nxt;
    if (out_load) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.status, out_res_r.pattern_id, out_res_r.match_valid};
  assign out_tlast  = out_res_r.last;

endmodule

`default_nettype wire

@@ hw/rtl/multi_pattern_string_matcher_core.sv @@
// One transaction in flight; the next is accepted the cycle after the last result is loaded,
// and each result may wait for the output register to be free. A match emits its results
// node by node along the output chain, passing over pattern-free nodes. Build visits every
// trie node and each of its letter slots. Reset (rst_n low) clears the memories.
`default_nettype none

module multi_pattern_string_matcher_core import mpsm_pkg::*; #(
  parameter int NODES        = NODES_DEF,
  parameter int ALPHABET     = ALPHABET_DEF,
  parameter int MAX_PATTERNS = MAX_PATTERNS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // op[1:0], symbol[6:2], zero[7]
  input  wire logic       in_tlast,   // pattern_end
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // match_valid[0], pattern_id[4:1], status[7:5]
  output logic            out_tlast
);

  localparam int NW     = $clog2(NODES);
  localparam int GDEPTH = NODES * ALPHABET;
  localparam int GAW    = $clog2(GDEPTH);

  logic                    g_we;
  logic [GAW-1:0]          g_waddr, g_raddr;
  logic [NW-1:0]           g_wdata, g_rdata;
  logic                    l_we;
  logic [NW-1:0]           l_waddr, n_raddr;
  logic [2*NW-1:0]         l_wdata, l_rdata;
  logic                    p_we;
  logic [NW-1:0]           p_waddr;
  logic [MAX_PATTERNS-1:0] p_wdata, p_rdata;
  logic                    q_we;
  logic [NW-1:0]           q_waddr, q_wdata, q_raddr, q_rdata;

  mpsm_ctrl #(
    .NODES(NODES), .ALPHABET(ALPHABET), .MAX_PATTERNS(MAX_PATTERNS)
  ) u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .g_we, .g_waddr, .g_wdata, .g_raddr, .g_rdata,
    .l_we, .l_waddr, .l_wdata, .n_raddr, .l_rdata,
    .p_we, .p_waddr, .p_wdata, .p_rdata,
    .q_we, .q_waddr, .q_wdata, .q_raddr, .q_rdata
  );

  mpsm_ram #(.DEPTH(GDEPTH), .WIDTH(NW)) u_goto (
    .clk, .we(g_we), .waddr(g_waddr), .wdata(g_wdata), .raddr(g_raddr), .rdata(g_rdata)
  );

  mpsm_ram #(.DEPTH(NODES), .WIDTH(2*NW)) u_link (
    .clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata), .raddr(n_raddr), .rdata(l_rdata)
  );

  mpsm_ram #(.DEPTH(NODES), .WIDTH(MAX_PATTERNS)) u_pat (
    .clk, .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(n_raddr), .rdata(p_rdata)
  );

  mpsm_ram #(.DEPTH(NODES), .WIDTH(NW)) u_queue (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata), .raddr(q_raddr), .rdata(q_rdata)
  );

endmodule

`default_nettype wire

@@ tb/mpsm_scoreboard.sv @@
// ----------------------------------------------------------------------------
// mpsm_scoreboard
// Watches both streams of the string matcher core, keeps its own copy of the
// trie and automaton, predicts the results of every accepted input
// transaction and compares each accepted output transaction in order.
// ----------------------------------------------------------------------------
`default_nettype none

module mpsm_scoreboard import mpsm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  input  wire logic       in_tready,
  input  wire logic [7:0] in_tdata,   // op[1:0], symbol[6:2], zero[7]
  input  wire logic       in_tlast,   // pattern_end
  input  wire logic       out_tvalid,
  input  wire logic       out_tready,
  input  wire logic [7:0] out_tdata,  // match_valid[0], pattern_id[4:1], status[7:5]
  input  wire logic       out_tlast,
  output int              fails,
  output int              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N = NODES_DEF;
  localparam int A = ALPHABET_DEF;
  localparam int P = MAX_PATTERNS_DEF;

  int           trans [N*A];
  int           fail_of [N];
  int           dict_of [N];
  logic [P-1:0] ends_at [N];
  int           node_cnt, pat_cnt, ins_node, txt_node;
  bit           is_built;
  result_t      results_due[$];

  assign pending = results_due.size();

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fails++;
  endtask

  task automatic due(input logic mv, input logic [3:0] id, input status_t st);
    result_t r;
    r.match_valid = mv;
    r.pattern_id  = id;
    r.status      = st;
    r.last        = 1'b1;
    results_due.insert(results_due.size(), r);
  endtask

  task automatic build_links();
    int q[N];
    int head, tail, u, v, f, c;
    head = 0;
    tail = 1;
    q[0] = 0;
    while (head < tail) begin
      u = q[head];
      head++;
      for (c = 0; c < A; c++) begin
        v = trans[u*A+c];
        if (v == 0) begin
          trans[u*A+c] = trans[fail_of[u]*A+c];
        end else begin
          f = (u != 0) ? trans[fail_of[u]*A+c] : 0;
          fail_of[v] = f;
          dict_of[v] = (ends_at[f] != 0) ? f : dict_of[f];
          if (tail < N) begin
            q[tail] = v;
            tail++;
          end
        end
      end
    end
    is_built = 1'b1;
    ins_node = 0;
  endtask

  task automatic predict(input op_t op, input int sym, input bit fin);
    int nxt, v, n, steps, p;
    if (sym >= A) sym = A - 1;
    case (op)
      OP_INSERT: begin
        if (is_built) begin
          due(1'b0, 4'd0, ST_INS_AFTER_BUILD);
        end else begin
          nxt = trans[ins_node*A+sym];
          if (nxt == 0 && node_cnt >= N) begin
            ins_node = 0;
            due(1'b0, 4'd0, ST_TRIE_FULL);
          end else begin
            if (nxt == 0) begin
              nxt = node_cnt;
              node_cnt++;
              trans[ins_node*A+sym] = nxt;
            end
            ins_node = nxt;
            if (!fin) begin
              due(1'b0, 4'd0, ST_OK);
            end else begin
              ins_node = 0;
              if (pat_cnt >= P) begin
                due(1'b0, 4'd0, ST_PAT_FULL);
              end else begin
                ends_at[nxt][pat_cnt] = 1'b1;
                due(1'b0, 4'(pat_cnt), ST_OK);
                pat_cnt++;
              end
            end
          end
        end
      end
      OP_BUILD: begin
        if (!is_built) build_links();
        due(1'b0, 4'd0, ST_OK);
      end
      OP_MATCH: begin
        if (!is_built) begin
          due(1'b0, 4'd0, ST_NOT_BUILT);
        end else begin
          txt_node = trans[txt_node*A+sym];
          v = txt_node;
          n = 0;
          steps = 0;
          while (v != 0 && steps < N && n < MAX_RESULTS) begin
            for (p = 0; p < P && n < MAX_RESULTS; p++) begin
              if (ends_at[v][p]) begin
                due(1'b1, 4'(p), ST_OK);
                results_due[results_due.size()-1].last = 1'b0;
                n++;
              end
            end
            v = dict_of[v];
            steps++;
          end
          if (n == 0) due(1'b0, 4'd0, ST_OK);
          else results_due[results_due.size()-1].last = 1'b1;
        end
      end
      default: begin
        txt_node = 0;
        due(1'b0, 4'd0, ST_OK);
      end
    endcase
  endtask

  initial fails = 0;

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      for (int i = 0; i < N*A; i++) trans[i] = 0;
      for (int i = 0; i < N; i++) begin
        fail_of[i] = 0;
        dict_of[i] = 0;
        ends_at[i] = '0;
      end
      node_cnt = 1;
      pat_cnt  = 0;
      ins_node = 0;
      txt_node = 0;
      is_built = 1'b0;
      results_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (results_due.size() == 0) begin
          report($sformatf("unexpected result data=%h last=%b", out_tdata, out_tlast));
        end else begin
          want = results_due.pop_front();
          if (out_tdata[0] !== want.match_valid)
            report($sformatf("match_valid %b, want %b", out_tdata[0], want.match_valid));
          if (out_tdata[4:1] !== want.pattern_id)
            report($sformatf("pattern_id %0d, want %0d", out_tdata[4:1], want.pattern_id));
          if (out_tdata[7:5] !== want.status)
            report($sformatf("status %0d, want %0d", out_tdata[7:5], want.status));
          if (out_tlast !== want.last)
            report($sformatf("last %b, want %b", out_tlast, want.last));
        end
      end
      if (in_tvalid && in_tready)
        predict(op_t'(in_tdata[1:0]), int'(in_tdata[6:2]), in_tlast);
    end
  end

endmodule

`default_nettype wire

@@ tb/multi_pattern_string_matcher_core_test.sv @@
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher_core_test
// Builds a pattern set (nested runs, saturating letters, random patterns),
// overflows the pattern table and the trie, builds the automaton and streams
// text through it under bursty input and stalling output.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_pattern_string_matcher_core_test;
  import mpsm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  int         fails, pending;
  bit         hold_req = 1'b0;
  int         burst_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  multi_pattern_string_matcher_core dut (.*);

  mpsm_scoreboard scb (.*);

  task automatic send(input op_t op, input int sym, input bit fin);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_tdata  = {1'b0, 5'(sym), op};
    in_tlast  = fin;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    burst_left--;
  endtask

  function automatic int pick_letter();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 31);
    return $urandom_range(0, 2);
  endfunction

  // receiver: modes of always ready, coin toss and mostly stalled, plus one long stall on hold_req
  initial begin
    int cyc, mode;
    bit held;
    cyc  = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_req && !held) begin
        out_tready = 1'b0;
        repeat (300) @(negedge clk);
        held = 1'b1;
      end
      mode = (cyc / 97) % 3;
      out_tready = (mode == 0) ? 1'b1 :
                   (mode == 1) ? 1'($urandom_range(0, 1)) :
                                 ($urandom_range(0, 9) == 0);
    end
  end

  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int len, r;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send(OP_MATCH, 0, 1'b0);
    send(OP_RESTART, 31, 1'b1);
    for (int k = 1; k <= 6; k++)
      for (int j = 0; j < k; j++) send(OP_INSERT, 0, j == k - 1);
    send(OP_INSERT, 26, 1'b0);
    send(OP_INSERT, 31, 1'b0);
    send(OP_INSERT, 25, 1'b1);
    send(OP_INSERT, 30, 1'b1);
    for (int p = 0; p < 8; p++) begin
      len = $urandom_range(1, 4);
      for (int j = 0; j < len; j++) send(OP_INSERT, pick_letter(), j == len - 1);
    end
    send(OP_INSERT, 1, 1'b1);           // pattern table full
    for (int i = 0; i < 260; i++)       // runs the trie out of nodes
      send(OP_INSERT, $urandom_range(0, 31), 1'b0);
    send(OP_BUILD, 0, 1'b0);
    send(OP_BUILD, 31, 1'b1);
    send(OP_INSERT, 2, 1'b1);
    hold_req = 1'b1;

    for (int i = 0; i < 140; i++) begin
      r = $urandom_range(0, 31);
      case (r)
        0: send(OP_RESTART, $urandom_range(0, 31), 1'($urandom_range(0, 1)));
        1: send(OP_INSERT, $urandom_range(0, 31), 1'($urandom_range(0, 1)));
        2: send(OP_BUILD, $urandom_range(0, 31), 1'($urandom_range(0, 1)));
        3: repeat (8) send(OP_MATCH, 0, 1'b0);
        default: send(OP_MATCH, ($urandom_range(0, 3) == 0) ? 0 : pick_letter(),
                      1'($urandom_range(0, 1)));
      endcase
    end
    in_tvalid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fails == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
